// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the queue RTL.
// Included by the top level only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition that must hold on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    `ASSERT_PROP(label, clk, rst_n, (cond), msg)

`endif

// ===== hdl/smpq_pkg.sv =====
// Shared types and constants for the stable minimum-first priority queue.
// No dependencies; imported by the cell and the top level.
package smpq_pkg;

    localparam int CAPACITY_DEF      = 16;
    localparam int PRIORITY_BITS_DEF = 16;
    localparam int PAYLOAD_BITS_DEF  = 32;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

// ===== hdl/smpq_cell.sv =====
// One slot of the sorted chain: holds a priority and payload and, on each
// operation, keeps its entry, takes the new one or takes a neighbour's.
// Depends on smpq_pkg.
module smpq_cell #(
    parameter int PRIORITY_BITS = smpq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = smpq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                      clk,
    input  smpq_pkg::cell_ctrl_t      ctrl,
    input  logic                      valid,
    input  logic signed [PRIORITY_BITS-1:0] new_prio,
    input  logic [PAYLOAD_BITS-1:0]   new_payload,
    input  logic                      ins_left,
    input  logic signed [PRIORITY_BITS-1:0] left_prio,
    input  logic [PAYLOAD_BITS-1:0]   left_payload,
    input  logic signed [PRIORITY_BITS-1:0] right_prio,
    input  logic [PAYLOAD_BITS-1:0]   right_payload,
    output logic                      ins,
    output logic signed [PRIORITY_BITS-1:0] prio,
    output logic [PAYLOAD_BITS-1:0]   payload
);
    import smpq_pkg::*;

    logic signed [PRIORITY_BITS-1:0] prio_reg;
    logic signed [PRIORITY_BITS-1:0] prio_next;
    logic [PAYLOAD_BITS-1:0]         payload_reg;
    logic [PAYLOAD_BITS-1:0]         payload_next;

    // The new entry belongs at or before this slot when the slot is empty or
    // holds a strictly larger priority, so equal priorities keep arrival order.
    assign ins = !valid || (prio_reg > new_prio);

    always_comb
    begin
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (ctrl.enq && ins)
        begin
            if (ins_left)
            begin
                prio_next    = left_prio;
                payload_next = left_payload;
            end
            else
            begin
                prio_next    = new_prio;
                payload_next = new_payload;
            end
        end
        else if (ctrl.deq)
        begin
            prio_next    = right_prio;
            payload_next = right_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

// ===== hdl/stable_min_priority_queue_unit.sv =====
// Stable minimum-first priority queue built as a sorted chain of cells.
// The result word is registered, valid in the cycle after the input word is taken.
// Throughput: one word per cycle unless output stalls; every cell updates in parallel.
// Reset (rst_n, asynchronous, active low) empties the queue and drops m_axis_tvalid.
// Depends on smpq_pkg, smpq_cell and assert_macros.svh.
`include "assert_macros.svh"

module stable_min_priority_queue_unit #(
    parameter int CAPACITY      = smpq_pkg::CAPACITY_DEF,
    parameter int PRIORITY_BITS = smpq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = smpq_pkg::PAYLOAD_BITS_DEF,
    localparam int OCC_W = $clog2(CAPACITY + 1),
    localparam int IN_W  = ((PRIORITY_BITS + PAYLOAD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((PRIORITY_BITS + PAYLOAD_BITS + OCC_W + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // priority_req, payload (lowest bit first), zero padded
    input  logic [IN_W-1:0]  s_axis_tdata,
    // cmd
    input  logic [0:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // out_priority, out_payload, occupancy (lowest bit first), zero padded
    output logic [OUT_W-1:0] m_axis_tdata,
    // status
    output logic [1:0]       m_axis_tuser
);
    import smpq_pkg::*;

    localparam int DATA_W = PRIORITY_BITS + PAYLOAD_BITS + OCC_W;

    logic                            in_acc;
    logic                            is_deq;
    logic                            full;
    logic                            empty;
    cell_ctrl_t                      ctrl;
    logic signed [PRIORITY_BITS-1:0] new_prio;
    logic [PAYLOAD_BITS-1:0]         new_payload;

    logic [OCC_W-1:0]                count_reg;
    logic [OCC_W-1:0]                count_next;

    logic                            out_valid_reg;
    status_t                         status_reg;
    status_t                         status_next;
    logic signed [PRIORITY_BITS-1:0] out_prio_reg;
    logic signed [PRIORITY_BITS-1:0] out_prio_next;
    logic [PAYLOAD_BITS-1:0]         out_payload_reg;
    logic [PAYLOAD_BITS-1:0]         out_payload_next;
    logic [OCC_W-1:0]                occ_reg;

    logic                            cell_valid [CAPACITY];
    logic                            cell_ins   [CAPACITY];
    logic signed [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
    logic [PAYLOAD_BITS-1:0]         cell_pay   [CAPACITY];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign is_deq        = (s_axis_tuser[0] == CMD_DEQ);
    assign new_prio      = s_axis_tdata[PRIORITY_BITS-1:0];
    assign new_payload   = s_axis_tdata[PRIORITY_BITS +: PAYLOAD_BITS];
    assign full          = (count_reg == OCC_W'(CAPACITY));
    assign empty         = (count_reg == '0);

    assign ctrl.enq = in_acc && !is_deq && !full;
    assign ctrl.deq = in_acc && is_deq && !empty;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                            ins_l;
            logic signed [PRIORITY_BITS-1:0] prio_l;
            logic [PAYLOAD_BITS-1:0]         pay_l;
            logic signed [PRIORITY_BITS-1:0] prio_r;
            logic [PAYLOAD_BITS-1:0]         pay_r;

            // Occupied slots always form a prefix of the chain.
            assign cell_valid[i] = (OCC_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign ins_l  = 1'b0;
                assign prio_l = new_prio;
                assign pay_l  = new_payload;
            end
            else
            begin : g_body
                assign ins_l  = cell_ins[i-1];
                assign prio_l = cell_prio[i-1];
                assign pay_l  = cell_pay[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign prio_r = cell_prio[i];
                assign pay_r  = cell_pay[i];
            end
            else
            begin : g_inner
                assign prio_r = cell_prio[i+1];
                assign pay_r  = cell_pay[i+1];
            end

            smpq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS),
                .PAYLOAD_BITS  (PAYLOAD_BITS)
            ) u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .valid         (cell_valid[i]),
                .new_prio      (new_prio),
                .new_payload   (new_payload),
                .ins_left      (ins_l),
                .left_prio     (prio_l),
                .left_payload  (pay_l),
                .right_prio    (prio_r),
                .right_payload (pay_r),
                .ins           (cell_ins[i]),
                .prio          (cell_prio[i]),
                .payload       (cell_pay[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next       = count_reg;
        out_prio_next    = '0;
        out_payload_next = '0;
        priority if (is_deq && empty)
        begin
            status_next = ST_EMPTY;
        end
        else if (is_deq)
        begin
            status_next      = ST_DEQUEUED;
            out_prio_next    = cell_prio[0];
            out_payload_next = cell_pay[0];
            count_next       = count_reg - OCC_W'(1);
        end
        else if (full)
        begin
            status_next = ST_FULL;
        end
        else
        begin
            status_next = ST_ENQUEUED;
            count_next  = count_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_ENQUEUED;
        end
        else
        begin
            if (in_acc)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            out_prio_reg    <= out_prio_next;
            out_payload_reg <= out_payload_next;
            occ_reg         <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {{(OUT_W - DATA_W){1'b0}}, occ_reg, out_payload_reg, out_prio_reg};

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= OCC_W'(CAPACITY),
        "entry count exceeds capacity")
    `ASSERT_PROP(a_enq_count, clk, rst_n, ctrl.enq |=> count_reg == $past(count_reg) + OCC_W'(1),
        "enqueue did not grow the queue by one")
    `ASSERT_PROP(a_empty_status, clk, rst_n, in_acc && is_deq && empty |=> m_axis_tuser == ST_EMPTY,
        "dequeue on empty queue not reported")
    `ASSERT_PROP(a_head_sorted, clk, rst_n, count_reg >= OCC_W'(2) |-> cell_prio[0] <= cell_prio[1],
        "head of the chain is out of order")

endmodule
